FILE: design/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

	localparam int RECIP_FRAC_BITS_DEF = 40;

	localparam int RAW_W      = 24;
	localparam int PRES_W     = 32;
	localparam int TEMP_W     = 24;
	localparam int CFG_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int OSR_W      = 3;
	localparam int OSR_N      = 8;
	localparam int PIPE_DEPTH = 12;

	localparam int PS_W      = 40;
	localparam int C16_PROD_W = 56;
	localparam int C12_PROD_W = 52;
	localparam int IN3_W     = 57;
	localparam int TP_W      = 44;
	localparam int IN2_W     = 60;
	localparam int Q_W       = 64;
	localparam int T02_W     = 57;
	localparam int TQ_W      = 53;
	localparam int TQ10_W    = 57;
	localparam int SUM_W     = 66;

	localparam int MUL_EXT_W = 128;
	localparam int CLAMP_BIT = 94;

	localparam logic signed [Q_W-1:0] Q32_SAT_POS = 64'sh4000_0000_0000_0000;
	localparam logic signed [Q_W-1:0] Q32_SAT_NEG = 64'shC000_0000_0000_0000;

	localparam logic signed [PRES_W-1:0] PRES_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [PRES_W-1:0] PRES_MIN = 32'sh8000_0000;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 24'sh7F_FFFF;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = 24'sh80_0000;

	localparam logic [63:0] OSR_SCALE [OSR_N] = '{
		64'd524288, 64'd1572864, 64'd3670016, 64'd7864320,
		64'd253952, 64'd516096, 64'd1040384, 64'd2088960
	};

	localparam logic [CFG_IDX_W-1:0] REG_COEF_LO   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_MID  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_HI   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRES_OSR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_OSR  = 3'd4;

	typedef struct packed {
		logic signed [11:0] c0;
		logic signed [11:0] c1;
		logic signed [19:0] c00;
		logic signed [19:0] c10;
		logic signed [15:0] c01;
		logic signed [15:0] c11;
		logic signed [15:0] c20;
		logic signed [15:0] c21;
		logic signed [15:0] c30;
		logic [OSR_W-1:0]   posr;
		logic [OSR_W-1:0]   tosr;
	} coef_t;

endpackage

`default_nettype wire

FILE: design/barometric_pressure_compensation.sv
`default_nettype none

// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-------------------------------------
// input    | in        | in_valid / in_ready  | raw_pressure, raw_temperature
// output   | out       | out_valid / out_ready| pressure_pa, temperature_decideg
// config   | in        | cfg_we               | cfg_index, cfg_wdata
//
// One pair per cycle is taken unless out_ready stalls the output; the rate is set by the 12-stage
// pipeline, whose four Q32 product units split each wide multiply into four partial products.
// Every stage advances when it is empty or the stage after it advances, so bubbles close up.
// Reset clears valid bits and configuration; in_ready stays low until run_q is registered high after reset.

module barometric_pressure_compensation #(
	parameter int RECIP_FRAC_BITS = bpc_pkg::RECIP_FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [bpc_pkg::RAW_W-1:0]     raw_pressure,
	input  wire logic signed [bpc_pkg::RAW_W-1:0]     raw_temperature,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [bpc_pkg::PRES_W-1:0]         pressure_pa,
	output logic signed [bpc_pkg::TEMP_W-1:0]         temperature_decideg,
	input  wire logic                                 cfg_we,
	input  wire logic [bpc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [bpc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import bpc_pkg::*;

	localparam int RECIP_W = RECIP_FRAC_BITS - 17;
	localparam int PP_W    = RECIP_FRAC_BITS + 8;
	localparam int SH      = RECIP_FRAC_BITS - 32;
	localparam int P_TR_W  = SUM_W - 32;
	localparam int T_TR_W  = TQ10_W - 32;

	localparam logic [63:0] ONE_Q = 64'd1 << RECIP_FRAC_BITS;
	localparam logic [RECIP_W-1:0] RECIP_TBL [OSR_N] = '{
		RECIP_W'((ONE_Q + OSR_SCALE[0] / 2) / OSR_SCALE[0]),
		RECIP_W'((ONE_Q + OSR_SCALE[1] / 2) / OSR_SCALE[1]),
		RECIP_W'((ONE_Q + OSR_SCALE[2] / 2) / OSR_SCALE[2]),
		RECIP_W'((ONE_Q + OSR_SCALE[3] / 2) / OSR_SCALE[3]),
		RECIP_W'((ONE_Q + OSR_SCALE[4] / 2) / OSR_SCALE[4]),
		RECIP_W'((ONE_Q + OSR_SCALE[5] / 2) / OSR_SCALE[5]),
		RECIP_W'((ONE_Q + OSR_SCALE[6] / 2) / OSR_SCALE[6]),
		RECIP_W'((ONE_Q + OSR_SCALE[7] / 2) / OSR_SCALE[7])
	};

	coef_t coef;

	logic                    run_q;
	logic [PIPE_DEPTH:1]     vld_q;
	logic [PIPE_DEPTH:1]     vld_in;
	logic [PIPE_DEPTH:1]     adv;

	logic [RECIP_W-1:0]      recip_p;
	logic [RECIP_W-1:0]      recip_t;
	logic signed [PP_W-1:0]  pp_s1;
	logic signed [PP_W-1:0]  pt_s1;
	logic signed [PS_W-1:0]  ps1;
	logic signed [PS_W-1:0]  ts1;

	logic signed [PS_W-1:0]       ps_s2;
	logic signed [C16_PROD_W-1:0] m30_s2;
	logic signed [C16_PROD_W-1:0] m21_s2;
	logic signed [C16_PROD_W-1:0] m01_s2;
	logic signed [C12_PROD_W-1:0] mt1_s2;

	logic signed [IN3_W-1:0]      in3_s3;
	logic signed [IN3_W-1:0]      in4_s3;
	logic signed [C16_PROD_W-1:0] t2_s3;
	logic signed [TQ_W-1:0]       tq_s3;
	logic signed [PS_W-1:0]       ps_s3;

	logic signed [IN3_W-1:0]  in4_s4;
	logic signed [T02_W-1:0]  t02_s4;
	logic signed [TQ10_W-1:0] tq10_s4;
	logic signed [Q_W-1:0]    tp_s4;

	logic signed [Q_W-1:0]    m3_s6;
	logic signed [PS_W-1:0]   ps_s7;
	logic signed [IN2_W-1:0]  in2_s7;
	logic signed [Q_W-1:0]    t3_s7;
	logic signed [Q_W-1:0]    t3_s10;
	logic signed [Q_W-1:0]    t1_s10;
	logic signed [T02_W-1:0]  t02_s10;
	logic signed [TQ10_W-1:0] tq10_s11;
	logic signed [SUM_W-1:0]  sum_s11;

	logic signed [P_TR_W-1:0] p_tr;
	logic signed [T_TR_W-1:0] t_tr;
	logic signed [PRES_W-1:0] pres_s12;
	logic signed [TEMP_W-1:0] temp_s12;

	bpc_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.coef      (coef)
	);

	// handshake and valid chain
	always_comb begin
		adv[PIPE_DEPTH] = ~vld_q[PIPE_DEPTH] | out_ready;
		for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
			adv[k] = ~vld_q[k] | adv[k+1];
		end
	end

	assign vld_in   = {vld_q[PIPE_DEPTH-1:1], in_valid & run_q};
	assign in_ready = adv[1] & run_q;
	assign out_valid = vld_q[PIPE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			vld_q <= '0;
		end else begin
			run_q <= 1'b1;
			for (int k = 1; k <= PIPE_DEPTH; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_in[k];
				end
			end
		end
	end

	// scale raw readings
	assign recip_p = RECIP_TBL[coef.posr];
	assign recip_t = RECIP_TBL[coef.tosr];
	assign ps1 = pp_s1[SH +: PS_W];
	assign ts1 = pt_s1[SH +: PS_W];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			pp_s1 <= PP_W'(raw_pressure) * PP_W'($signed({1'b0, recip_p}));
			pt_s1 <= PP_W'(raw_temperature) * PP_W'($signed({1'b0, recip_t}));
		end
		if (adv[2]) begin
			ps_s2  <= ps1;
			m30_s2 <= C16_PROD_W'(ps1) * C16_PROD_W'($signed(coef.c30));
			m21_s2 <= C16_PROD_W'(ps1) * C16_PROD_W'($signed(coef.c21));
			m01_s2 <= C16_PROD_W'(ts1) * C16_PROD_W'($signed(coef.c01));
			mt1_s2 <= C12_PROD_W'(ts1) * C12_PROD_W'($signed(coef.c1));
		end
		if (adv[3]) begin
			ps_s3  <= ps_s2;
			in3_s3 <= (IN3_W'($signed(coef.c20)) <<< 32) + IN3_W'(m30_s2);
			in4_s3 <= (IN3_W'($signed(coef.c11)) <<< 32) + IN3_W'(m21_s2);
			t2_s3  <= m01_s2;
			tq_s3  <= (TQ_W'($signed(coef.c0)) <<< 31) + TQ_W'(mt1_s2);
		end
		if (adv[4]) begin
			in4_s4  <= in4_s3;
			t02_s4  <= (T02_W'($signed(coef.c00)) <<< 32) + T02_W'(t2_s3);
			tq10_s4 <= (TQ10_W'(tq_s3) <<< 3) + (TQ10_W'(tq_s3) <<< 1);
		end
		if (adv[7]) begin
			in2_s7 <= (IN2_W'($signed(coef.c10)) <<< 32) + IN2_W'(m3_s6);
		end
		if (adv[11]) begin
			sum_s11 <= SUM_W'(t1_s10) + SUM_W'(t3_s10) + SUM_W'(t02_s10);
		end
		if (adv[12]) begin
			pres_s12 <= (p_tr > P_TR_W'(PRES_MAX)) ? PRES_MAX :
				(p_tr < P_TR_W'(PRES_MIN)) ? PRES_MIN : p_tr[PRES_W-1:0];
			temp_s12 <= (t_tr > T_TR_W'(TEMP_MAX)) ? TEMP_MAX :
				(t_tr < T_TR_W'(TEMP_MIN)) ? TEMP_MIN : t_tr[TEMP_W-1:0];
		end
	end

	// Ts * Ps
	bpc_mulq #(.AW(PS_W), .BW(PS_W)) u_mul_tp (
		.clk (clk),
		.en  (adv[4:2]),
		.a   (ts1),
		.b   (ps1),
		.q   (tp_s4)
	);

	// Ps * (c20 + Ps*c30)
	bpc_mulq #(.AW(PS_W), .BW(IN3_W)) u_mul_in3 (
		.clk (clk),
		.en  (adv[6:4]),
		.a   (ps_s3),
		.b   (in3_s3),
		.q   (m3_s6)
	);

	// Ts*Ps * (c11 + Ps*c21)
	bpc_mulq #(.AW(TP_W), .BW(IN3_W)) u_mul_t3 (
		.clk (clk),
		.en  (adv[7:5]),
		.a   (tp_s4[TP_W-1:0]),
		.b   (in4_s4),
		.q   (t3_s7)
	);

	// Ps * (c10 + Ps*(...))
	bpc_mulq #(.AW(PS_W), .BW(IN2_W)) u_mul_t1 (
		.clk (clk),
		.en  (adv[10:8]),
		.a   (ps_s7),
		.b   (in2_s7),
		.q   (t1_s10)
	);

	bpc_dly #(.W(PS_W), .N(4)) u_dly_ps (
		.clk (clk),
		.en  (adv[7:4]),
		.d   (ps_s3),
		.q   (ps_s7)
	);

	bpc_dly #(.W(Q_W), .N(3)) u_dly_t3 (
		.clk (clk),
		.en  (adv[10:8]),
		.d   (t3_s7),
		.q   (t3_s10)
	);

	bpc_dly #(.W(T02_W), .N(6)) u_dly_t02 (
		.clk (clk),
		.en  (adv[10:5]),
		.d   (t02_s4),
		.q   (t02_s10)
	);

	bpc_dly #(.W(TQ10_W), .N(7)) u_dly_tq (
		.clk (clk),
		.en  (adv[11:5]),
		.d   (tq10_s4),
		.q   (tq10_s11)
	);

	// truncate toward zero
	assign p_tr = sum_s11[SUM_W-1:32] + P_TR_W'(sum_s11[SUM_W-1] & (|sum_s11[31:0]));
	assign t_tr = tq10_s11[TQ10_W-1:32] + T_TR_W'(tq10_s11[TQ10_W-1] & (|tq10_s11[31:0]));

	assign pressure_pa         = pres_s12;
	assign temperature_decideg = temp_s12;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		run_q && !out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	a_enter_stage1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[1])
		else $error("transferred item missing from first stage");

	a_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> $countones(vld_q) == $past($countones(vld_q))
			+ $past(int'(in_valid && in_ready)) - $past(int'(out_valid && out_ready)))
		else $error("pipeline occupancy lost or duplicated an item");

endmodule

`default_nettype wire

FILE: design/bpc_coef.sv
`default_nettype none

module bpc_coef (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bpc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output bpc_pkg::coef_t                        coef
);
	import bpc_pkg::*;

	logic [CFG_DATA_W-1:0] lo_q;
	logic [CFG_DATA_W-1:0] mid_q;
	logic [CFG_DATA_W-1:0] hi_q;
	logic [OSR_W-1:0]      posr_q;
	logic [OSR_W-1:0]      tosr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q   <= '0;
			mid_q  <= '0;
			hi_q   <= '0;
			posr_q <= '0;
			tosr_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_LO:  lo_q   <= cfg_wdata;
				REG_COEF_MID: mid_q  <= cfg_wdata;
				REG_COEF_HI:  hi_q   <= cfg_wdata;
				REG_PRES_OSR: posr_q <= cfg_wdata[OSR_W-1:0];
				REG_TEMP_OSR: tosr_q <= cfg_wdata[OSR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		coef.c0   = lo_q[47:36];
		coef.c1   = lo_q[35:24];
		coef.c00  = lo_q[23:4];
		coef.c10  = {lo_q[3:0], mid_q[47:32]};
		coef.c01  = mid_q[31:16];
		coef.c11  = mid_q[15:0];
		coef.c20  = hi_q[47:32];
		coef.c21  = hi_q[31:16];
		coef.c30  = hi_q[15:0];
		coef.posr = posr_q;
		coef.tosr = tosr_q;
	end

endmodule

`default_nettype wire

FILE: design/bpc_dly.sv
`default_nettype none

module bpc_dly #(
	parameter int W = 8,
	parameter int N = 2
) (
	input  wire logic          clk,
	input  wire logic [N-1:0]  en,
	input  wire logic [W-1:0]  d,
	output logic      [W-1:0]  q
);

	logic [W-1:0] line_q [N];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			line_q[0] <= d;
		end
		for (int i = 1; i < N; i++) begin
			if (en[i]) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[N-1];

endmodule

`default_nettype wire

FILE: design/bpc_mulq.sv
`default_nettype none

module bpc_mulq #(
	parameter int AW = 40,
	parameter int BW = 40
) (
	input  wire logic                         clk,
	input  wire logic [2:0]                   en,
	input  wire logic signed [AW-1:0]         a,
	input  wire logic signed [BW-1:0]         b,
	output logic signed [bpc_pkg::Q_W-1:0]    q
);
	import bpc_pkg::*;

	localparam int AL   = AW / 2;
	localparam int AH   = AW - AL;
	localparam int BL   = BW / 2;
	localparam int BH   = BW - BL;
	localparam int LL_W = AL + BL;
	localparam int LH_W = AL + BH + 1;
	localparam int HL_W = AH + BL + 1;
	localparam int HH_W = AH + BH;
	localparam int PW   = AW + BW;

	localparam logic signed [MUL_EXT_W-1:0] LIM =
		{{(MUL_EXT_W-CLAMP_BIT-1){1'b0}}, 1'b1, {CLAMP_BIT{1'b0}}};

	logic [AL-1:0]        a_lo;
	logic signed [AH-1:0] a_hi;
	logic [BL-1:0]        b_lo;
	logic signed [BH-1:0] b_hi;

	logic [LL_W-1:0]        p_ll_s1;
	logic signed [LH_W-1:0] p_lh_s1;
	logic signed [HL_W-1:0] p_hl_s1;
	logic signed [HH_W-1:0] p_hh_s1;
	logic signed [PW-1:0]   prod_s2;
	logic signed [Q_W-1:0]  q_s3;

	logic signed [MUL_EXT_W-1:0] ext;
	logic                        frac_nz;
	logic signed [Q_W-1:0]       q_d;

	assign a_lo = a[AL-1:0];
	assign a_hi = $signed(a[AW-1:AL]);
	assign b_lo = b[BL-1:0];
	assign b_hi = $signed(b[BW-1:BL]);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_ll_s1 <= LL_W'(a_lo) * LL_W'(b_lo);
			p_lh_s1 <= LH_W'($signed({1'b0, a_lo})) * LH_W'(b_hi);
			p_hl_s1 <= HL_W'(a_hi) * HL_W'($signed({1'b0, b_lo}));
			p_hh_s1 <= HH_W'(a_hi) * HH_W'(b_hi);
		end
		if (en[1]) begin
			prod_s2 <= (PW'(p_hh_s1) <<< LL_W) + (PW'(p_lh_s1) <<< BL)
				+ (PW'(p_hl_s1) <<< AL) + PW'($signed({1'b0, p_ll_s1}));
		end
		if (en[2]) begin
			q_s3 <= q_d;
		end
	end

	always_comb begin
		ext     = {{(MUL_EXT_W-PW){prod_s2[PW-1]}}, prod_s2};
		frac_nz = |prod_s2[31:0];
		if (ext >= LIM) begin
			q_d = Q32_SAT_POS;
		end else if (ext <= -LIM) begin
			q_d = Q32_SAT_NEG - Q_W'(frac_nz);
		end else begin
			q_d = ext[Q_W+31:32];
		end
	end

	assign q = q_s3;

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import bpc_pkg::*;

	localparam int RECIP_BITS  = RECIP_FRAC_BITS_DEF;
	localparam int SEGMENTS    = 9;
	localparam int SEG_ITEMS   = 200;
	localparam int CYCLE_LIMIT = 400000;
	localparam int KEEP        = -1;

	localparam logic signed [RAW_W-1:0] RAW_MAX = 24'sh7F_FFFF;
	localparam logic signed [RAW_W-1:0] RAW_MIN = 24'sh80_0000;

	typedef struct packed {
		logic signed [PRES_W-1:0] pressure;
		logic signed [TEMP_W-1:0] temperature;
	} reading_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] w0;
		logic [CFG_DATA_W-1:0] w1;
		logic [CFG_DATA_W-1:0] w2;
		logic [OSR_W-1:0]      posr;
		logic [OSR_W-1:0]      tosr;
	} cal_set_t;

	typedef struct packed {
		int                       sel;
		logic signed [RAW_W-1:0]  praw;
		logic signed [RAW_W-1:0]  traw;
		logic                     typed;
		logic signed [PRES_W-1:0] p;
		logic signed [TEMP_W-1:0] t;
	} dir_row_t;

	// c0/c00 extremes, c1 sign bit, full-scale coefficients, product clamp both ways
	localparam cal_set_t DIR_CALS [8] = '{
		'{48'h7FF0_007F_FFF0, 48'h0, 48'h0, 3'd0, 3'd0},
		'{48'h8000_0080_0000, 48'h0, 48'h0, 3'd7, 3'd7},
		'{48'h0008_0000_0000, 48'h0, 48'h0, 3'd4, 3'd4},
		'{48'h0007_FF00_0000, 48'h1234_5678_9ABC, 48'hFEDC_BA98_7654, 3'd1, 3'd2},
		'{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 3'd3, 3'd5},
		'{48'h0000_007F_FFF7, 48'hFFFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 3'd4, 3'd4},
		'{48'h0000_0080_0007, 48'hFFFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 3'd4, 3'd4},
		'{48'h0000_0000_0008, 48'h0000_8000_8000, 48'h8000_8000_8000, 3'd6, 3'd0}
	};

	localparam dir_row_t DIR_ROWS [21] = '{
		'{KEEP, 24'sd0,       24'sd0,       1'b1, 32'sd0,       24'sd0},
		'{KEEP, RAW_MAX,      RAW_MIN,      1'b1, 32'sd0,       24'sd0},
		'{KEEP, RAW_MIN,      RAW_MAX,      1'b1, 32'sd0,       24'sd0},
		'{0,    RAW_MAX,      RAW_MIN,      1'b1, 32'sd524287,  24'sd10235},
		'{KEEP, 24'sd0,       24'sd0,       1'b1, 32'sd524287,  24'sd10235},
		'{1,    RAW_MIN,      RAW_MAX,      1'b1, -32'sd524288, -24'sd10240},
		'{KEEP, -24'sd1,      24'sd1,       1'b1, -32'sd524288, -24'sd10240},
		'{2,    24'sd0,       RAW_MAX,      1'b0, 32'sd0,       24'sd0},
		'{KEEP, 24'sd0,       RAW_MIN,      1'b0, 32'sd0,       24'sd0},
		'{KEEP, -24'sd1,      -24'sd1,      1'b0, 32'sd0,       24'sd0},
		'{3,    RAW_MAX,      RAW_MAX,      1'b0, 32'sd0,       24'sd0},
		'{KEEP, RAW_MIN,      24'sd1,       1'b0, 32'sd0,       24'sd0},
		'{4,    RAW_MAX,      RAW_MIN,      1'b0, 32'sd0,       24'sd0},
		'{KEEP, 24'sd1,       -24'sd1,      1'b0, 32'sd0,       24'sd0},
		'{5,    RAW_MAX,      RAW_MAX,      1'b1, PRES_MAX,     24'sd0},
		'{KEEP, RAW_MIN,      RAW_MAX,      1'b0, 32'sd0,       24'sd0},
		'{6,    RAW_MIN,      RAW_MIN,      1'b1, PRES_MIN,     24'sd0},
		'{KEEP, RAW_MAX,      RAW_MIN,      1'b0, 32'sd0,       24'sd0},
		'{7,    RAW_MAX,      RAW_MAX,      1'b0, 32'sd0,       24'sd0},
		'{KEEP, RAW_MIN,      RAW_MIN,      1'b0, 32'sd0,       24'sd0},
		'{KEEP, 24'sh55_5555, 24'shAA_AAAA, 1'b0, 32'sd0,       24'sd0}
	};

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [RAW_W-1:0]  raw_pressure = '0;
	logic signed [RAW_W-1:0]  raw_temperature = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [PRES_W-1:0] pressure_pa;
	logic signed [TEMP_W-1:0] temperature_decideg;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

	logic [CFG_DATA_W-1:0] coef_word [3] = '{default: '0};
	logic [OSR_W-1:0]      p_osr = '0;
	logic [OSR_W-1:0]      t_osr = '0;

	reading_t expected_readings [$];
	reading_t oldest_reading;
	int       mismatches = 0;
	int       send_idle = 0;
	int       recv_stall = 0;
	int       cycles = 0;

	barometric_pressure_compensation dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.raw_pressure        (raw_pressure),
		.raw_temperature     (raw_temperature),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.pressure_pa         (pressure_pa),
		.temperature_decideg (temperature_decideg),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_wdata           (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [CFG_DATA_W-1:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[CFG_DATA_W-1:0];
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_word();
		case ($urandom_range(7))
		0: return '0;
		1: return '1;
		default: return rand48();
		endcase
	endfunction

	function automatic logic signed [RAW_W-1:0] pick_raw();
		case ($urandom_range(15))
		0: return RAW_MIN;
		1: return RAW_MAX;
		2: return '0;
		3: return '1;
		default: return RAW_W'($urandom);
		endcase
	endfunction

	function automatic longint osr_recip(logic [OSR_W-1:0] idx);
		logic [63:0] k;
		k = OSR_SCALE[idx];
		return longint'(((64'd1 << RECIP_BITS) + k / 2) / k);
	endfunction

	// Q32 x Q32, floor to Q32, magnitude clamped at 2^62
	function automatic longint q32_mul(longint a, longint b);
		logic [63:0]  ua;
		logic [63:0]  ub;
		logic [127:0] full;
		logic [63:0]  mag;
		ua = a[63] ? -a : a;
		ub = b[63] ? -b : b;
		full = {64'd0, ua} * {64'd0, ub};
		if (full[127:94] != '0) begin
			mag = Q32_SAT_POS;
		end else begin
			mag = {2'b00, full[93:32]};
		end
		if (a[63] == b[63]) begin
			return mag;
		end
		return -mag - {63'd0, |full[31:0]};
	endfunction

	function automatic coef_t unpack_coefs();
		logic [143:0] cal;
		coef_t        c;
		cal = {coef_word[0], coef_word[1], coef_word[2]};
		c.c0 = cal[143:132];
		c.c1 = cal[131:120];
		c.c00 = cal[119:100];
		c.c10 = cal[99:80];
		c.c01 = cal[79:64];
		c.c11 = cal[63:48];
		c.c20 = cal[47:32];
		c.c21 = cal[31:16];
		c.c30 = cal[15:0];
		c.posr = p_osr;
		c.tosr = t_osr;
		return c;
	endfunction

	function automatic reading_t compensate(logic signed [RAW_W-1:0] praw,
			logic signed [RAW_W-1:0] traw);
		coef_t              c;
		longint             ps;
		longint             ts;
		longint             in2;
		longint             in3;
		longint             in4;
		longint             tp;
		longint             tq;
		longint             it;
		logic signed [127:0] acc;
		reading_t           r;
		c = unpack_coefs();
		ps = (longint'(praw) * osr_recip(c.posr)) >>> (RECIP_BITS - 32);
		ts = (longint'(traw) * osr_recip(c.tosr)) >>> (RECIP_BITS - 32);
		in3 = (longint'(c.c20) <<< 32) + ps * longint'(c.c30);
		in2 = (longint'(c.c10) <<< 32) + q32_mul(ps, in3);
		tp = q32_mul(ts, ps);
		in4 = (longint'(c.c11) <<< 32) + ps * longint'(c.c21);
		acc = q32_mul(ps, in2);
		acc += q32_mul(tp, in4);
		acc += ts * longint'(c.c01);
		acc += longint'(c.c00) <<< 32;
		acc = acc[127] ? -((-acc) >>> 32) : acc >>> 32;
		if (acc > PRES_MAX) begin
			r.pressure = PRES_MAX;
		end else if (acc < PRES_MIN) begin
			r.pressure = PRES_MIN;
		end else begin
			r.pressure = acc[PRES_W-1:0];
		end
		tq = ((longint'(c.c0) <<< 31) + ts * longint'(c.c1)) * 10;
		it = (tq < 0) ? -((-tq) >>> 32) : tq >>> 32;
		if (it > TEMP_MAX) begin
			r.temperature = TEMP_MAX;
		end else if (it < TEMP_MIN) begin
			r.temperature = TEMP_MIN;
		end else begin
			r.temperature = it[TEMP_W-1:0];
		end
		return r;
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
		REG_COEF_LO:  coef_word[0] = data;
		REG_COEF_MID: coef_word[1] = data;
		REG_COEF_HI:  coef_word[2] = data;
		REG_PRES_OSR: p_osr = data[OSR_W-1:0];
		REG_TEMP_OSR: t_osr = data[OSR_W-1:0];
		default: ;
		endcase
	endtask

	task automatic apply_settings(input cal_set_t s);
		cfg_write(REG_COEF_LO, s.w0);
		cfg_write(REG_COEF_MID, s.w1);
		cfg_write(REG_COEF_HI, s.w2);
		cfg_write(REG_PRES_OSR, (rand48() & ~48'h7) | 48'(s.posr));
		cfg_write(REG_TEMP_OSR, (rand48() & ~48'h7) | 48'(s.tosr));
		// spare indexes must leave the settings untouched
		for (int k = REG_TEMP_OSR + 1; k < 2 ** CFG_IDX_W; k++) begin
			cfg_write(CFG_IDX_W'(k), rand48());
		end
		cfg_we <= 1'b0;
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (expected_readings.size() != 0) @(posedge clk);
	endtask

	task automatic send_pair(input logic signed [RAW_W-1:0] p, input logic signed [RAW_W-1:0] t,
			input reading_t want);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_pressure <= p;
		raw_temperature <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_readings.push_back(want);
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_readings.size() == 0) begin
				$error("pressure_pa/temperature_decideg: unexpected transfer, got %0d / %0d",
					pressure_pa, temperature_decideg);
				mismatches++;
			end else begin
				oldest_reading = expected_readings.pop_front();
				if (pressure_pa !== oldest_reading.pressure) begin
					$error("pressure_pa: expected %0d, got %0d",
						oldest_reading.pressure, pressure_pa);
					mismatches++;
				end
				if (temperature_decideg !== oldest_reading.temperature) begin
					$error("temperature_decideg: expected %0d, got %0d",
						oldest_reading.temperature, temperature_decideg);
					mismatches++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic signed [RAW_W-1:0] p;
		logic signed [RAW_W-1:0] t;
		cal_set_t                s;
		send_idle = 11;
		recv_stall = 60;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIR_ROWS); i++) begin
			if (DIR_ROWS[i].sel != KEEP) begin
				drain_pipeline();
				apply_settings(DIR_CALS[DIR_ROWS[i].sel]);
			end
			p = DIR_ROWS[i].praw;
			t = DIR_ROWS[i].traw;
			if (DIR_ROWS[i].typed) begin
				send_pair(p, t, reading_t'{DIR_ROWS[i].p, DIR_ROWS[i].t});
			end else begin
				send_pair(p, t, compensate(p, t));
			end
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain_pipeline();
			s = '{pick_word(), pick_word(), pick_word(), OSR_W'(seg % OSR_N),
				OSR_W'(OSR_N - 1 - seg % OSR_N)};
			apply_settings(s);
			if (seg < 3) begin
				send_idle = 11;
				recv_stall = 60;
			end else if (seg < 6) begin
				send_idle = 60;
				recv_stall = 11;
			end else begin
				send_idle = 0;
				recv_stall = 0;
			end
			for (int n = 0; n < SEG_ITEMS; n++) begin
				p = pick_raw();
				t = pick_raw();
				send_pair(p, t, compensate(p, t));
			end
		end

		drain_pipeline();
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
